// ===== rtl/eag_pkg.sv =====
// Shared types and constants for the event avalanche grouper.
package eag_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_W     = 17;
    localparam int DUR_W       = 16;
    localparam int GAP_W       = 16;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    // 0.5 in signed Q8.8; an event is strictly above it
    localparam logic signed [SAMPLE_BITS-1:0] EVENT_THRESHOLD = 16'sd128;
    localparam logic [COUNT_W-1:0]            COUNT_MAX       = '1;
    localparam logic [DUR_W-1:0]              DUR_MAX         = '1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          end_of_array;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] avalanche_size;
        logic [DUR_W-1:0]   av_duration;
        logic               last_of_array;
    } out_item_t;

    // write request into the result queue; second only ever comes with first
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

// ===== rtl/eag_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per transfer.
module eag_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  eag_pkg::push_t    push,
    input  eag_pkg::out_item_t wr_data0,
    input  eag_pkg::out_item_t wr_data1,
    output logic              room,
    output logic              rd_valid,
    input  logic              rd_stall,
    output eag_pkg::out_item_t rd_data
);
    import eag_pkg::*;

    out_item_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  pop;
    logic [FIFO_PTR_W-1:0] wr_ptr_plus1;

    assign rd_valid     = (count_reg != '0);
    assign rd_data      = mem_reg[rd_ptr_reg];
    assign pop          = rd_valid && !rd_stall;
    // two free slots guarantee a push of two never overflows
    assign room         = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + FIFO_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.first && push.second)
        begin
            wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(2);
            count_next  = count_next + FIFO_CNT_W'(2);
        end
        else if (push.first)
        begin
            wr_ptr_next = wr_ptr_plus1;
            count_next  = count_next + FIFO_CNT_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(1);
            count_next  = count_next - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            mem_reg[wr_ptr_reg] <= wr_data0;
        end
        if (push.first && push.second)
        begin
            mem_reg[wr_ptr_plus1] <= wr_data1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count beyond depth");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> push.first)
        else $error("second push without first");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2))
        else $error("double push into a nearly full queue");

endmodule

// ===== rtl/event_avalanche_grouper.sv =====
// Event avalanche grouper: groups above-threshold samples into avalanches.
// Results pass the input stage register, then the result queue. Throughput: one sample
// per cycle while the queue has room; the queue drains one result per unstalled cycle.
// A sample that closes an avalanche and ends the array yields two results.
// Reset (rst_n, async, low) clears the gap register, index, open avalanche and queue.
module event_avalanche_grouper #(
    parameter int MAX_LEN = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  eag_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output eag_pkg::out_item_t out_data,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data
);
    import eag_pkg::*;

    // index width follows the array length; compare width covers index and gap
    localparam int IDX_W = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
    localparam int CMP_W = (IDX_W > GAP_W) ? IDX_W : GAP_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_LEN - 1);

    // configuration
    logic [GAP_W-1:0]   max_gap_reg;

    // input stage
    logic               in_vld_reg, in_vld_next;
    in_item_t           in_item_reg;
    logic               in_xfer;
    logic               fire;
    logic               room;

    // open avalanche state
    logic [IDX_W-1:0]   sample_index_reg, sample_index_next;
    logic               seen_reg, seen_next;
    logic [IDX_W-1:0]   start_reg, start_next;
    logic [IDX_W-1:0]   prev_reg, prev_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // per-sample decode
    logic               is_event;
    logic               close_av;
    logic               end_av;
    logic [CMP_W-1:0]   gap_ext;
    logic [CMP_W-1:0]   dur_close_ext;
    logic [CMP_W-1:0]   dur_end_ext;
    logic [IDX_W-1:0]   end_prev;
    logic [IDX_W-1:0]   end_start;
    logic [COUNT_W-1:0] end_count;

    push_t              push;
    out_item_t          res_close;
    out_item_t          res_end;
    out_item_t          wr_data0;
    out_item_t          wr_data1;

    // Hold the sample in the input stage until the queue has room for two results.
    assign in_stall = in_vld_reg && !room;
    assign in_xfer  = in_valid && !in_stall;
    assign fire     = in_vld_reg && room;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_xfer)
        begin
            in_vld_next = 1'b1;
        end
        else if (fire)
        begin
            in_vld_next = 1'b0;
        end
    end

    // Decode the held sample: event test and gap against the last event.
    assign is_event = (in_item_reg.sample > EVENT_THRESHOLD);
    assign gap_ext  = CMP_W'(sample_index_reg - prev_reg);
    assign close_av = is_event && seen_reg && (gap_ext > CMP_W'(max_gap_reg));

    always_comb
    begin
        start_next = start_reg;
        prev_next  = prev_reg;
        count_next = count_reg;
        seen_next  = seen_reg;
        if (is_event)
        begin
            // start a fresh avalanche, or extend the open one with a saturating count
            if (!seen_reg || close_av)
            begin
                start_next = sample_index_reg;
                count_next = COUNT_W'(1);
            end
            else if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
            prev_next = sample_index_reg;
            seen_next = 1'b1;
        end
    end

    // State after this sample but before the end-of-array clear feeds the flush result.
    assign end_av    = in_item_reg.end_of_array && seen_next;
    assign end_prev  = prev_next;
    assign end_start = start_next;
    assign end_count = count_next;

    assign dur_close_ext = CMP_W'(prev_reg - start_reg);
    assign dur_end_ext   = CMP_W'(end_prev - end_start);

    always_comb
    begin
        res_close.avalanche_size = count_reg;
        res_close.av_duration    = (dur_close_ext > CMP_W'(DUR_MAX))
                                   ? DUR_MAX : DUR_W'(dur_close_ext);
        res_close.last_of_array  = 1'b0;
        res_end.avalanche_size   = end_count;
        res_end.av_duration      = (dur_end_ext > CMP_W'(DUR_MAX))
                                   ? DUR_MAX : DUR_W'(dur_end_ext);
        res_end.last_of_array    = 1'b1;
    end

    // Push the closed avalanche first, then the flushed one.
    always_comb
    begin
        push.first  = fire && (close_av || end_av);
        push.second = fire && close_av && end_av;
        wr_data0    = close_av ? res_close : res_end;
        wr_data1    = res_end;
    end

    // Advance the index with saturation; drop everything at array end.
    always_comb
    begin
        sample_index_next = sample_index_reg;
        if (in_item_reg.end_of_array)
        begin
            sample_index_next = '0;
        end
        else if (sample_index_reg != IDX_LAST)
        begin
            sample_index_next = sample_index_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_gap_reg      <= '0;
            in_vld_reg       <= 1'b0;
            sample_index_reg <= '0;
            seen_reg         <= 1'b0;
            start_reg        <= '0;
            prev_reg         <= '0;
            count_reg        <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_gap_reg <= cfg_wr_data;
            end
            in_vld_reg <= in_vld_next;
            if (fire)
            begin
                sample_index_reg <= sample_index_next;
                if (in_item_reg.end_of_array)
                begin
                    seen_reg  <= 1'b0;
                    start_reg <= '0;
                    prev_reg  <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    seen_reg  <= seen_next;
                    start_reg <= start_next;
                    prev_reg  <= prev_next;
                    count_reg <= count_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_item_reg <= in_data;
        end
    end

    eag_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data0 (wr_data0),
        .wr_data1 (wr_data1),
        .room     (room),
        .rd_valid (out_valid),
        .rd_stall (out_stall),
        .rd_data  (out_data)
    );

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_item_reg.end_of_array |=> !seen_reg && sample_index_reg == '0)
        else $error("state not cleared after array end");

    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_reg |-> count_reg == '0)
        else $error("event count without open avalanche");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> prev_reg >= start_reg && count_reg != '0)
        else $error("open avalanche inconsistent");

    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg && !room)
        else $error("input stalled with free stage");

endmodule

// ===== test/eag_avalanche_checker.sv =====
// Checker for the event avalanche grouper: predicts avalanche reports and compares them.
module eag_avalanche_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  eag_pkg::in_item_t         in_data,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  eag_pkg::out_item_t        out_data,
    input  logic                      cfg_wr_en,
    input  logic [eag_pkg::GAP_W-1:0] cfg_wr_data,
    output int                        mismatch_count,
    output int                        pending_avalanches
);
    import eag_pkg::*;

    localparam logic [15:0] IDX_LAST   = 16'hFFFF;
    localparam int          REPORT_MAX = 10;

    logic [GAP_W-1:0]   gap_limit;
    logic [15:0]        sample_idx;
    logic               av_open;
    logic [15:0]        av_first;
    logic [15:0]        av_last;
    logic [COUNT_W-1:0] av_count;
    out_item_t          expected_avalanches[$];
    int                 errs;

    task automatic clear_avalanche();
        sample_idx = '0;
        av_open    = 1'b0;
        av_first   = '0;
        av_last    = '0;
        av_count   = '0;
    endtask

    function automatic out_item_t make_report(logic last);
        out_item_t rep;
        rep.avalanche_size = av_count;
        rep.av_duration    = (av_last < av_first) ? '0 : av_last - av_first;
        rep.last_of_array  = last;
        return rep;
    endfunction

    task automatic predict_avalanches(in_item_t item);
        logic        is_ev;
        logic [16:0] ev_gap;
        is_ev = $signed(item.sample) > $signed(EVENT_THRESHOLD);
        if (is_ev)
        begin
            if (!av_open)
            begin
                av_open  = 1'b1;
                av_first = sample_idx;
                av_count = COUNT_W'(1);
            end
            else
            begin
                ev_gap = {1'b0, sample_idx} - {1'b0, av_last};
                if (ev_gap > {1'b0, gap_limit})
                begin
                    expected_avalanches = {expected_avalanches, make_report(1'b0)};
                    av_first = sample_idx;
                    av_count = COUNT_W'(1);
                end
                else if (av_count != COUNT_MAX)
                begin
                    av_count = av_count + 1'b1;
                end
            end
            av_last = sample_idx;
        end
        if (item.end_of_array)
        begin
            if (av_open)
                expected_avalanches = {expected_avalanches, make_report(1'b1)};
            clear_avalanche();
        end
        else if (sample_idx != IDX_LAST)
        begin
            sample_idx = sample_idx + 1'b1;
        end
    endtask

    task automatic check_report(out_item_t got);
        out_item_t want;
        if (expected_avalanches.size() == 0)
        begin
            errs++;
            if (errs <= REPORT_MAX)
                $display("unexpected avalanche: size %0d dur %0d last %0b",
                         got.avalanche_size, got.av_duration, got.last_of_array);
            return;
        end
        want = expected_avalanches.pop_front();
        if (got.avalanche_size !== want.avalanche_size
            || got.av_duration !== want.av_duration
            || got.last_of_array !== want.last_of_array)
        begin
            errs++;
            if (errs <= REPORT_MAX)
                $display("mismatch: want %0d/%0d/%0b got %0d/%0d/%0b",
                         want.avalanche_size, want.av_duration, want.last_of_array,
                         got.avalanche_size, got.av_duration, got.last_of_array);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit = '0;
            clear_avalanche();
            expected_avalanches.delete();
            errs = 0;
            mismatch_count     <= 0;
            pending_avalanches <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                gap_limit = cfg_wr_data;
            if (out_valid && !out_stall)
                check_report(out_data);
            if (in_valid && !in_stall)
                predict_avalanches(in_data);
            mismatch_count     <= errs;
            pending_avalanches <= expected_avalanches.size();
        end
    end

endmodule

// ===== test/event_avalanche_grouper_test.sv =====
// Testbench top for the event avalanche grouper: stimulus, stall pattern and verdict.
module event_avalanche_grouper_test;
    import eag_pkg::*;

    // A correct run ends well inside this limit even with every item and result at
    // its longest wait; the limit leaves plenty of room on top of that.
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int PHASE_ITEMS   = 80;
    localparam int SETTLE_CYCLES = 4;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    in_item_t           in_data;
    logic               out_valid;
    logic               out_stall;
    out_item_t          out_data;
    logic               cfg_wr_en;
    logic [GAP_W-1:0]   cfg_wr_data;

    int                 mismatch_count;
    int                 pending_avalanches;
    int                 cycle_cnt;
    int                 in_idle_max;
    int                 out_idle_max;

    event_avalanche_grouper u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    eag_avalanche_checker u_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .in_data            (in_data),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .out_data           (out_data),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .mismatch_count     (mismatch_count),
        .pending_avalanches (pending_avalanches)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop: count cycles and fail if the run never reaches its verdict.
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Draw a wait length; at least a third of the draws give no wait at all so that
    // back-to-back transfers show up even in idling phases.
    function automatic int idle_draw(int top);
        if (top == 0 || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, top);
    endfunction

    // Pick a sample: an event (strictly above 0.5) with the given odds, otherwise
    // a non-event anywhere from the most negative value up to the threshold itself.
    function automatic logic signed [15:0] draw_sample(int ev_pct);
        int          pick;
        logic [15:0] raw;
        pick = $urandom_range(0, 9);
        if ($urandom_range(0, 99) < ev_pct)
        begin
            if (pick == 0)
                return 16'sd129;
            if (pick == 1)
                return 16'sd32767;
            return 16'($urandom_range(129, 32767));
        end
        if (pick == 0)
            return 16'sd128;
        if (pick == 1)
            return 16'sh8000;
        // offset by 2^15 to span -32768 .. 128
        raw = 16'($urandom_range(0, 32896) + 32768);
        return raw;
    endfunction

    // Result side: for every result, hold stall for a random number of cycles,
    // then drop it and wait for the transfer.
    initial
    begin
        int waits;
        out_stall <= 1'b0;
        forever
        begin
            waits = idle_draw(out_idle_max);
            if (waits > 0)
            begin
                out_stall <= 1'b1;
                repeat (waits) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Offer one sample: idle first if drawn, then hold it until the transfer.
    // Valid stays high into the next sample when no idle is drawn.
    task automatic push_sample(input logic signed [15:0] value, input logic eoa);
        int waits;
        waits = idle_draw(in_idle_max);
        if (waits > 0)
        begin
            in_valid <= 1'b0;
            repeat (waits) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{sample: value, end_of_array: eoa};
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stop sending and wait until every predicted avalanche has been reported,
    // then allow the pipeline to empty of samples that report nothing.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_avalanches != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_gap(input logic [GAP_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_array(input int len, input int ev_pct);
        for (int i = 0; i < len; i++)
            push_sample(draw_sample(ev_pct), i == len - 1);
    endtask

    initial
    begin
        int gap_pick;
        int sent;
        int len;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_idle_max  = 12;
        out_idle_max = 12;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, gap still at its reset value of zero.
        // Single sample at the threshold: not an event, array reports nothing.
        push_sample(16'sd128, 1'b1);
        // Adjacent events split at gap zero; the last sample closes one
        // avalanche and ends the array on the same transfer (two reports).
        push_sample(16'sd32767, 1'b0);
        push_sample(16'sd32767, 1'b0);
        push_sample(16'sd128, 1'b0);
        push_sample(16'sd129, 1'b1);
        // Most negative sample, no events.
        push_sample(16'sh8000, 1'b1);
        // One-sample array holding the smallest event.
        push_sample(16'sd129, 1'b1);

        // Small gap: events at distance 1 join, distance 3 splits.
        write_gap(16'd2);
        push_sample(16'sd200, 1'b0);
        push_sample(16'sd129, 1'b0);
        push_sample(-16'sd1, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd300, 1'b0);
        push_sample(16'sd128, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd5000, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sd127, 1'b1);

        // Random phases: well-formed arrays of random length and event density,
        // a new gap and a new idling pattern per phase.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: gap_pick = 1;
                1: gap_pick = $urandom_range(3, 40);
                2: gap_pick = 0;
                3: gap_pick = 65535;
                default: gap_pick = $urandom_range(0, 65535);
            endcase
            write_gap(16'(gap_pick));
            in_idle_max  = (phase == 1 || phase == 3) ? 0 : 12;
            out_idle_max = (phase == 1 || phase == 2) ? 0 : 12;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(31, 80)
                                                  : $urandom_range(1, 30);
                send_array(len, $urandom_range(5, 95));
                sent += len;
            end
        end

        // Drain, then give the block time to show any stray report.
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_avalanches != 0);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_avalanches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== event_avalanche_grouper.f =====
rtl/eag_pkg.sv
rtl/eag_fifo.sv
rtl/event_avalanche_grouper.sv
test/eag_avalanche_checker.sv
test/event_avalanche_grouper_test.sv
